// ===== sv/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the pulse channel synthesizer
// Holds the command format passed from the front end to the back end, the
// action and parameter codes, and the fixed-point constants.
// ----------------------------------------------------------------------------
package pcs_pkg;

	// Default configuration of the block.
	localparam int CHANNELS_DEF    = 3;
	localparam int GRID_BITS_DEF   = 256;
	localparam int SAMPLE_RATE_DEF = 44100;

	// Input action codes.
	localparam logic [1:0] ACT_RENDER = 2'd0;
	localparam logic [1:0] ACT_PARAM  = 2'd1;
	localparam logic [1:0] ACT_GRID   = 2'd2;

	// Channel parameter selects.
	localparam logic [2:0] PSEL_FREQ   = 3'd0;
	localparam logic [2:0] PSEL_DUTY   = 3'd1;
	localparam logic [2:0] PSEL_VOLUME = 3'd2;
	localparam logic [2:0] PSEL_SOURCE = 3'd3;
	localparam logic [2:0] PSEL_DEPTH  = 3'd4;
	localparam logic [2:0] PSEL_TARGET = 3'd5;

	// Modulation targets.
	localparam logic [7:0] TGT_FREQ   = 8'd0;
	localparam logic [7:0] TGT_DUTY   = 8'd1;
	localparam logic [7:0] TGT_VOLUME = 8'd2;

	// Modulation source codes.
	localparam logic [7:0] MOD_OFF    = 8'hFF;
	localparam logic [7:0] MOD_CH_LO  = 8'hF0;
	localparam logic [7:0] MOD_CH_HI  = 8'hF2;

	// Fixed-point constants.
	localparam logic [15:0] Q8_MAX     = 16'hFF00;
	localparam logic [7:0]  DUTY_RESET = 8'd128;
	localparam int          CF_W       = 25;
	localparam int          STEP_SHIFT = 24;
	localparam int          DIVIDEND_W = CF_W + STEP_SHIFT;
	localparam int          STEP_W     = 32;
	localparam int          OUT_W      = 18;

	// Command kinds after classification.
	typedef enum logic [1:0] {
		CMD_RENDER = 2'd0,
		CMD_PARAM  = 2'd1,
		CMD_GRID   = 2'd2
	} cmd_kind_t;

	// One queued command.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  channel;
		logic [2:0]  sel;
		logic [15:0] value;
		logic [7:0]  gidx;
		logic        gval;
	} cmd_t;

	// Back end status seen by the top level.
	typedef struct packed {
		logic idle;
		logic div_wait;
	} stat_t;

endpackage

// ===== sv/pcs_div.sv =====
// ----------------------------------------------------------------------------
// pcs_div: reciprocal multiplier for the phase step
// Forms floor(cf * 2^24 / DIVISOR) by multiplying the scaled frequency with a
// precomputed reciprocal, one of its three 17-bit slices per cycle, and keeps
// the low 32 bits of the quotient.
// ----------------------------------------------------------------------------
module pcs_div
	import pcs_pkg::*;
#(
	parameter int DIVISOR = SAMPLE_RATE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CF_W-1:0]   dividend,
	output logic              busy,
	output logic              done,
	output logic [STEP_W-1:0] quot
);

	// The full dividend is dividend * 2^STEP_SHIFT, at most DIVIDEND_W bits.
	// With SH = DIVIDEND_W + ceil(log2(DIVISOR)) and RCP = ceil(2^SH / DIVISOR)
	// the quotient is exactly (dividend * RCP) >> (SH - STEP_SHIFT).
	localparam int RLOG   = $clog2(DIVISOR);
	localparam int SH     = DIVIDEND_W + RLOG;
	localparam int PART_W = 17;
	localparam int RCP_W  = 3 * PART_W;
	localparam int QLO    = SH - STEP_SHIFT;
	localparam int ACC_W  = QLO + STEP_W;
	localparam int PP_W   = CF_W + PART_W;
	localparam logic [SH:0] POW      = (SH+1)'(1) << SH;
	localparam logic [SH:0] RCP_FULL = (POW + (SH+1)'(DIVISOR - 1)) / (SH+1)'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
	localparam logic [1:0]  LAST     = 2'd2;

	logic [CF_W-1:0]   cf_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        cnt_q;
	logic              busy_q;
	logic [PART_W-1:0] part;
	logic [PP_W-1:0]   pprod;
	logic [ACC_W-1:0]  addend;

	// One partial product per cycle, aligned to its reciprocal slice.
	always_comb begin
		case (cnt_q)
			2'd0:    part = RCP[PART_W-1:0];
			2'd1:    part = RCP[2*PART_W-1:PART_W];
			default: part = RCP[RCP_W-1:2*PART_W];
		endcase
		pprod = PP_W'(cf_q) * PP_W'(part);
		case (cnt_q)
			2'd0:    addend = ACC_W'(pprod);
			2'd1:    addend = ACC_W'(pprod) << PART_W;
			default: addend = ACC_W'(pprod) << (2 * PART_W);
		endcase
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			cf_q  <= dividend;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == LAST);
	assign quot = acc_q[ACC_W-1:QLO];

endmodule

// ===== sv/pcs_front.sv =====
// ----------------------------------------------------------------------------
// pcs_front: input front end
// Accepts input transactions, drops those that have no effect, and queues
// the rest in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module pcs_front
	import pcs_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int GRID_BITS = GRID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [1:0]  channel,
	input  logic [2:0]  param_select,
	input  logic [15:0] param_value,
	input  logic [7:0]  grid_index,
	input  logic        grid_value,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	cmd_t       cmd_new;
	logic       push;
	logic       pop;

	// Classify the incoming transaction.
	always_comb begin
		keep            = 1'b0;
		cmd_new.kind    = CMD_RENDER;
		cmd_new.channel = channel;
		cmd_new.sel     = param_select;
		cmd_new.value   = param_value;
		cmd_new.gidx    = grid_index;
		cmd_new.gval    = grid_value;
		unique case (action)
			ACT_RENDER: begin
				keep = 1'b1;
			end
			ACT_PARAM: begin
				cmd_new.kind = CMD_PARAM;
				keep = (32'(channel) < CHANNELS) && (param_select <= PSEL_TARGET);
			end
			ACT_GRID: begin
				cmd_new.kind = CMD_GRID;
				keep = (32'(grid_index) < GRID_BITS);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

// ===== sv/pcs_back.sv =====
// ----------------------------------------------------------------------------
// pcs_back: command back end
// Applies parameter and grid writes, and renders one sample by working
// through the channels with a small sequencer and a shared phase-step unit.
// ----------------------------------------------------------------------------
module pcs_back
	import pcs_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int GRID_BITS = GRID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  div_start,
	output logic [CF_W-1:0]       div_dividend,
	input  logic                  div_done,
	input  logic [STEP_W-1:0]     div_quot,
	output stat_t                 stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    sample
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int GI_W = $clog2(GRID_BITS);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_CUR  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_UPD  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CH_W-1:0] ch_q;

	// Channel state.
	logic [15:0]              freq_q  [CHANNELS];
	logic [7:0]               duty_q  [CHANNELS];
	logic [7:0]               vol_q   [CHANNELS];
	logic [7:0]               src_q   [CHANNELS];
	logic signed [15:0]       depth_q [CHANNELS];
	logic [7:0]               tgt_q   [CHANNELS];
	logic [31:0]              phase_q [CHANNELS];
	logic signed [OUT_W-1:0]  last_q  [CHANNELS];

	// Per-sample working values.
	logic [CF_W-1:0]          cf_q [CHANNELS];
	logic [15:0]              cd_q [CHANNELS];
	logic [15:0]              cv_q [CHANNELS];
	logic signed [33:0]       prod_q;
	logic [47:0]              phprod_q;
	logic signed [19:0]       mix_q;
	logic                     out_valid_q;
	logic signed [15:0]       sample_q;

	// Modulation grid.
	logic                     grid_mem [GRID_BITS];
	logic [GRID_BITS-1:0]     gvalid_q;
	logic                     grid_rd_q;
	logic                     gv_rd_q;

	logic [7:0]               src;
	logic [1:0]               k;
	logic                     is_chan;
	logic                     k_ok;
	logic [CH_W-1:0]          k_idx;
	logic signed [33:0]       prod_adj;
	logic signed [17:0]       off;
	logic signed [25:0]       off_ext;
	logic signed [25:0]       f_sum;
	logic signed [25:0]       d_sum;
	logic signed [25:0]       v_sum;
	logic [CF_W-1:0]          cf_n;
	logic [15:0]              cd_n;
	logic [15:0]              cv_n;
	logic                     silent;
	logic                     high;
	logic [8:0]               r255;
	logic [16:0]              mag;
	logic signed [OUT_W-1:0]  chan_out;
	logic signed [17:0]       mix_c;
	logic signed [17:0]       mix_r;
	logic signed [16:0]       half;
	logic                     out_free;

	// Modulation offset and clamped current values for channel ch_q.
	always_comb begin
		src      = src_q[ch_q];
		k        = src[1:0];
		is_chan  = (src >= MOD_CH_LO) && (src <= MOD_CH_HI);
		k_ok     = (32'(k) < CHANNELS);
		k_idx    = k_ok ? k[CH_W-1:0] : '0;
		// Truncate the product toward zero before dropping 16 bits.
		prod_adj = prod_q + (prod_q[33] ? 34'sd65535 : 34'sd0);
		if (src == MOD_OFF) begin
			off = '0;
		end else if (is_chan) begin
			off = k_ok ? prod_adj[33:16] : 18'sd0;
		end else if ((32'(src) < GRID_BITS) && gv_rd_q && grid_rd_q) begin
			off = {{2{depth_q[ch_q][15]}}, depth_q[ch_q]};
		end else begin
			off = '0;
		end
		off_ext = {{8{off[17]}}, off};
		f_sum = $signed({2'b00, freq_q[ch_q], 8'h00});
		d_sum = $signed({10'b0, duty_q[ch_q], 8'h00});
		v_sum = $signed({10'b0, vol_q[ch_q], 8'h00});
		if (src != MOD_OFF) begin
			case (tgt_q[ch_q])
				TGT_FREQ:   f_sum = f_sum + off_ext;
				TGT_DUTY:   d_sum = d_sum + off_ext;
				TGT_VOLUME: v_sum = v_sum + off_ext;
				default:    ;
			endcase
		end
		cf_n = f_sum[25] ? '0 : f_sum[CF_W-1:0];
		if (d_sum[25]) begin
			cd_n = '0;
		end else if (d_sum > $signed({10'b0, Q8_MAX})) begin
			cd_n = Q8_MAX;
		end else begin
			cd_n = d_sum[15:0];
		end
		if (v_sum[25]) begin
			cv_n = '0;
		end else if (v_sum > $signed({10'b0, Q8_MAX})) begin
			cv_n = Q8_MAX;
		end else begin
			cv_n = v_sum[15:0];
		end
	end

	// Channel output: sign from the duty compare, size vol * 256 / 255.
	always_comb begin
		silent = (cf_q[ch_q] == '0) || (cv_q[ch_q] == '0);
		high   = (phprod_q < {cd_q[ch_q], 32'h0});
		r255   = 9'(cv_q[ch_q][15:8]) + 9'(cv_q[ch_q][7:0]);
		mag    = {1'b0, cv_q[ch_q]} + 17'(cv_q[ch_q][15:8])
		       + 17'(r255 >= 9'd255) + 17'(r255 >= 9'd510);
		chan_out = high ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
	end

	// Final mix: clamp to one, halve toward zero, clamp to Q1.15.
	always_comb begin
		if (mix_q > 20'sd65536) begin
			mix_c = 18'sd65536;
		end else if (mix_q < -20'sd65536) begin
			mix_c = -18'sd65536;
		end else begin
			mix_c = mix_q[17:0];
		end
		mix_r = mix_c + $signed({17'b0, mix_c[17]});
		half  = mix_r[17:1];
	end

	assign out_free     = !out_valid_q || out_ready;
	assign cmd_ready    = (state_q == ST_IDLE);
	assign div_start    = (state_q == ST_MUL) && !silent;
	assign div_dividend = cf_q[ch_q];

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			gvalid_q    <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				freq_q[c]  <= '0;
				duty_q[c]  <= DUTY_RESET;
				vol_q[c]   <= '0;
				src_q[c]   <= MOD_OFF;
				depth_q[c] <= '0;
				tgt_q[c]   <= '0;
				phase_q[c] <= '0;
				last_q[c]  <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ch_q <= '0;
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_RENDER: state_q <= ST_RD;
							CMD_GRID: gvalid_q[cmd.gidx[GI_W-1:0]] <= 1'b1;
							CMD_PARAM: begin
								case (cmd.sel)
									PSEL_FREQ:   freq_q[cmd.channel[CH_W-1:0]] <= cmd.value;
									PSEL_DUTY:   duty_q[cmd.channel[CH_W-1:0]] <= cmd.value[7:0];
									PSEL_VOLUME: vol_q[cmd.channel[CH_W-1:0]] <= cmd.value[7:0];
									PSEL_SOURCE: src_q[cmd.channel[CH_W-1:0]] <= cmd.value[7:0];
									PSEL_DEPTH:  depth_q[cmd.channel[CH_W-1:0]] <= $signed(cmd.value);
									PSEL_TARGET: tgt_q[cmd.channel[CH_W-1:0]] <= cmd.value[7:0];
									default:     ;
								endcase
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_CUR;
				end
				ST_CUR: begin
					if (ch_q == CH_LAST) begin
						ch_q    <= '0;
						state_q <= ST_MUL;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MUL: begin
					state_q <= silent ? ST_UPD : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (silent) begin
						last_q[ch_q] <= '0;
					end else begin
						phase_q[ch_q] <= phase_q[ch_q] + div_quot;
						last_q[ch_q]  <= chan_out;
					end
					if (ch_q == CH_LAST) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result valid: raised when a render completes, dropped once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			mix_q <= '0;
		end
		if (state_q == ST_RD) begin
			prod_q <= last_q[k_idx] * depth_q[ch_q];
		end
		if (state_q == ST_CUR) begin
			cf_q[ch_q] <= cf_n;
			cd_q[ch_q] <= cd_n;
			cv_q[ch_q] <= cv_n;
		end
		if (state_q == ST_MUL) begin
			phprod_q <= 48'(phase_q[ch_q]) * 48'(Q8_MAX);
		end
		if ((state_q == ST_UPD) && !silent) begin
			mix_q <= mix_q + 20'(chan_out);
		end
		if ((state_q == ST_OUT) && out_free) begin
			sample_q <= (half > 17'sd32767) ? 16'sh7FFF : half[15:0];
		end
	end

	// Grid memory: written by grid commands, read once per channel.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd_valid && (cmd.kind == CMD_GRID)) begin
			grid_mem[cmd.gidx[GI_W-1:0]] <= cmd.gval;
		end
		if (state_q == ST_RD) begin
			grid_rd_q <= grid_mem[src[GI_W-1:0]];
			gv_rd_q   <= gvalid_q[src[GI_W-1:0]];
		end
	end

	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.div_wait = (state_q == ST_DIV);
	assign out_valid     = out_valid_q;
	assign sample        = sample_q;

endmodule

// ===== sv/pulse_channel_synthesizer.sv =====
// ----------------------------------------------------------------------------
// pulse_channel_synthesizer: three-channel pulse-wave sound generator
// Top level: input front end with command queue, back end, phase-step unit.
// ----------------------------------------------------------------------------
// Parameter and grid writes are applied in the back end's idle state. A render
// walks the channels twice: first, per channel, a read state that fetches the
// modulation source and a state that forms the clamped frequency, duty and
// volume; then, per audible channel, a state that starts the phase step, a wait
// while the reciprocal multiplier forms it and an update state (a silent channel
// skips the wait), and finally an output state, which holds while the last
// sample has not been taken. Two commands can wait in the queue meanwhile.
module pulse_channel_synthesizer
	import pcs_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int GRID_BITS   = GRID_BITS_DEF,
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [1:0]         channel,
	input  logic [2:0]         param_select,
	input  logic [15:0]        param_value,
	input  logic [7:0]         grid_index,
	input  logic               grid_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample
);

	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_t                  cmd;
	logic                  div_start;
	logic [CF_W-1:0]       div_dividend;
	logic                  div_busy;
	logic                  div_done;
	logic [STEP_W-1:0]     div_quot;
	stat_t                 stat;

	// Front end: classify and queue transactions.
	pcs_front #(
		.CHANNELS  (CHANNELS),
		.GRID_BITS (GRID_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.channel      (channel),
		.param_select (param_select),
		.param_value  (param_value),
		.grid_index   (grid_index),
		.grid_value   (grid_value),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	// Phase-step unit.
	pcs_div #(
		.DIVISOR (SAMPLE_RATE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Back end: channel state and sample rendering.
	pcs_back #(
		.CHANNELS  (CHANNELS),
		.GRID_BITS (GRID_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_done     (div_done),
		.div_quot     (div_quot),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample)
	);

	// The phase-step unit only runs while the back end waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> stat.div_wait)
		else $error("phase-step unit busy outside the wait state");

	// A phase step is never started while one is still running.
	a_div_single: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("phase-step unit restarted while busy");

	// A new result only appears at the end of a render.
	a_out_from_render: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!stat.idle))
		else $error("result raised without a render");

endmodule
